### rtl/core/p80_pkg.sv
// Shared types, tables and round functions for the PRESENT-80 cipher core.
`default_nettype none

package p80_pkg;

   localparam int unsigned BLOCK_W  = 64;
   localparam int unsigned KEY_W    = 80;
   localparam int unsigned ROUNDS   = 31;
   localparam int unsigned NUM_KEYS = 32;

   // Cycles the key cell row needs to refill after a key write or reset.
   localparam logic [4:0] KEY_SETTLE = 5'd31;

   // Register indexes on the configuration port.
   localparam logic REG_KEY_UPPER = 1'b0;
   localparam logic REG_KEY_LOWER = 1'b1;

   // Direction codes carried with each item.
   localparam logic DIR_ENCRYPT = 1'b0;
   localparam logic DIR_DECRYPT = 1'b1;

   typedef struct packed {
      logic                 valid;
      logic                 dir;
      logic [BLOCK_W-1:0]   text;
   } stage_type;

   localparam logic [3:0] SBOX_FWD [16] = '{
      4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
      4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
   };

   localparam logic [3:0] SBOX_INV [16] = '{
      4'h5, 4'he, 4'hf, 4'h8, 4'hc, 4'h1, 4'h2, 4'hd,
      4'hb, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'ha
   };

   function automatic logic [BLOCK_W-1:0] sub_fwd(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] o;
      for (int n = 0; n < 16; n++) begin
         o[4*n +: 4] = SBOX_FWD[s[4*n +: 4]];
      end
      return o;
   endfunction

   function automatic logic [BLOCK_W-1:0] sub_inv(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] o;
      for (int n = 0; n < 16; n++) begin
         o[4*n +: 4] = SBOX_INV[s[4*n +: 4]];
      end
      return o;
   endfunction

   // Bit k moves to (16*k) mod 63; bit 63 stays in place.
   function automatic logic [BLOCK_W-1:0] perm_fwd(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] o;
      o = '0;
      for (int k = 0; k < 63; k++) begin
         o[(16*k) % 63] = s[k];
      end
      o[63] = s[63];
      return o;
   endfunction

   // Inverse wiring: bit k moves to (4*k) mod 63; bit 63 stays in place.
   function automatic logic [BLOCK_W-1:0] perm_inv(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] o;
      o = '0;
      for (int k = 0; k < 63; k++) begin
         o[(4*k) % 63] = s[k];
      end
      o[63] = s[63];
      return o;
   endfunction

   // One key schedule step: rotate left by 61, S-box on the top nibble,
   // round counter into bits 19..15.
   function automatic logic [KEY_W-1:0] key_step(input logic [KEY_W-1:0] k,
                                                 input logic [4:0] ctr);
      logic [KEY_W-1:0] r;
      r = {k[18:0], k[79:19]};
      r[79:76] = SBOX_FWD[r[79:76]];
      r[19:15] = r[19:15] ^ ctr;
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/p80_key_cell.sv
// One cell of the key schedule row: holds one 80-bit key state.
`default_nettype none

module p80_key_cell (
   input  wire logic                      clock,
   input  wire logic [p80_pkg::KEY_W-1:0] key_prev,
   input  wire logic [4:0]                round_num,
   output logic      [p80_pkg::KEY_W-1:0] key_state
);

   logic [p80_pkg::KEY_W-1:0] key_ff;
   logic [p80_pkg::KEY_W-1:0] key_in;

   assign key_in = p80_pkg::key_step(key_prev, round_num);

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_state = key_ff;

endmodule

`default_nettype wire

### rtl/core/p80_round_cell.sv
// One cipher round cell with its own stage register and flow control.
`default_nettype none

module p80_round_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire p80_pkg::stage_type          stage_prev,
   input  wire logic [p80_pkg::BLOCK_W-1:0] rk_enc,
   input  wire logic [p80_pkg::BLOCK_W-1:0] rk_dec,
   input  wire logic                        ready_down,
   output logic                             ready_up,
   output p80_pkg::stage_type               stage_next
);

   p80_pkg::stage_type         stage_ff;
   logic [p80_pkg::BLOCK_W-1:0] mixed;
   logic [p80_pkg::BLOCK_W-1:0] text_in;

   always_comb begin
      if (stage_prev.dir == p80_pkg::DIR_DECRYPT) begin
         mixed   = stage_prev.text ^ rk_dec;
         text_in = p80_pkg::sub_inv(p80_pkg::perm_inv(mixed));
      end else begin
         mixed   = stage_prev.text ^ rk_enc;
         text_in = p80_pkg::perm_fwd(p80_pkg::sub_fwd(mixed));
      end
   end

   // The stage takes a new item when it is empty or its item moves on.
   assign ready_up = !stage_ff.valid || ready_down;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (ready_up) begin
         stage_ff.valid <= stage_prev.valid;
      end
      if (ready_up) begin
         stage_ff.dir  <= stage_prev.dir;
         stage_ff.text <= text_in;
      end
   end

   assign stage_next = stage_ff;

endmodule

`default_nettype wire

### rtl/core/present80_block_cipher.sv
// Top level of the PRESENT-80 cipher: key registers, key cell row, round cell row.
// Throughput: one item per cycle while the key cell row is settled and the result
// stream is not stalled, set by the row of 31 registered round cells. Each item
// passes the round cells, then the output register. After reset and every key
// register write, req_tready is low while the key cell row refills its round keys.
// Reset is synchronous and active high; it clears the keys to zero and empties
// every stage of the round cell row and the output register.
`default_nettype none

module present80_block_cipher (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input item stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // bits 63..0: text_in
   input  wire logic        req_tuser,   // bit 0: req_type (0 encrypt, 1 decrypt)
   // Result item stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [63:0] rsp_tdata,   // bits 63..0: text_out
   // Configuration port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic      [63:0] csr_prdata,
   output logic             csr_pready
);

   localparam int unsigned NK = p80_pkg::NUM_KEYS;

   // ---------------------------------------------------------------------
   // Configuration registers. Register 0 is the upper 64 key bits at byte
   // address 0, register 1 the lower 16 key bits at byte address 8. The
   // register is selected by address bit 3 alone.
   // ---------------------------------------------------------------------
   logic [63:0] key_upper_ff;
   logic [15:0] key_lower_ff;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_upper_ff <= '0;
         key_lower_ff <= '0;
      end else if (csr_write) begin
         if (csr_paddr[3] == p80_pkg::REG_KEY_UPPER) begin
            key_upper_ff <= csr_pwdata;
         end else begin
            key_lower_ff <= csr_pwdata[15:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[3] == p80_pkg::REG_KEY_UPPER) ?
                       key_upper_ff : {48'd0, key_lower_ff};

   // ---------------------------------------------------------------------
   // Settle counter. The key cell row carries a new key to its end cell by cell,
   // so no item is accepted until the count runs out.
   // ---------------------------------------------------------------------
   logic [4:0] settle_ff;
   logic       settled;

   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         settle_ff <= p80_pkg::KEY_SETTLE;
      end else if (settle_ff != 5'd0) begin
         settle_ff <= settle_ff - 5'd1;
      end
   end

   assign settled = (settle_ff == 5'd0);

   // ---------------------------------------------------------------------
   // Key cell row. Entry 0 is the key itself; each cell applies one step
   // of the key schedule to its left neighbor every cycle, so entry r holds
   // the key state of round r once the row has settled. Round key r is the
   // upper 64 bits of entry r.
   // ---------------------------------------------------------------------
   logic [p80_pkg::KEY_W-1:0]   key_state [NK];
   logic [p80_pkg::BLOCK_W-1:0] round_key [NK];

   assign key_state[0] = {key_upper_ff, key_lower_ff};

   for (genvar r = 1; r < NK; r++) begin : g_key
      p80_key_cell u_key_cell (
         .clock     (clock),
         .key_prev  (key_state[r-1]),
         .round_num (5'(r)),
         .key_state (key_state[r])
      );
   end

   for (genvar r = 0; r < NK; r++) begin : g_rk
      assign round_key[r] = key_state[r][p80_pkg::KEY_W-1 -: p80_pkg::BLOCK_W];
   end

   // ---------------------------------------------------------------------
   // Round cell row. Cell i runs round i: encryption uses round key i,
   // decryption round key 31-i. Each cell holds one item and passes it on
   // when its right neighbor can take it, so the row fills bubbles even
   // while the output register waits.
   // ---------------------------------------------------------------------
   p80_pkg::stage_type stage [NK];
   logic               stage_ready [NK];

   assign stage[0].valid = req_tvalid && settled;
   assign stage[0].dir   = req_tuser;
   assign stage[0].text  = req_tdata;

   for (genvar i = 0; i < p80_pkg::ROUNDS; i++) begin : g_round
      p80_round_cell u_round_cell (
         .clock      (clock),
         .reset      (reset),
         .stage_prev (stage[i]),
         .rk_enc     (round_key[i]),
         .rk_dec     (round_key[NK-1-i]),
         .ready_down (stage_ready[i+1]),
         .ready_up   (stage_ready[i]),
         .stage_next (stage[i+1])
      );
   end

   assign req_tready = stage_ready[0] && settled;

   // ---------------------------------------------------------------------
   // Output register with the final whitening key: round key 31 for
   // encryption, round key 0 for decryption.
   // ---------------------------------------------------------------------
   logic        out_valid_ff;
   logic [63:0] out_text_ff;
   logic [63:0] out_text_in;

   assign stage_ready[NK-1] = !out_valid_ff || rsp_tready;
   assign out_text_in = stage[NK-1].text ^
                        ((stage[NK-1].dir == p80_pkg::DIR_DECRYPT) ?
                         round_key[0] : round_key[NK-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (stage_ready[NK-1]) begin
         out_valid_ff <= stage[NK-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[NK-1]) begin
         out_text_ff <= out_text_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_text_ff;

endmodule

`default_nettype wire

### rtl/core/p80_checker.sv
// Port-level assertions for the PRESENT-80 cipher top level, bound to it.
`default_nettype none

module p80_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic        csr_psel,
   input wire logic        csr_penable,
   input wire logic        csr_pwrite
);

   // A waiting result item holds its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // A key write blocks input while the round keys refill.
   a_key_write_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite |=> !req_tready)
      else $error("input accepted right after a key write");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item shown right after reset");

   // Reset also starts the key refill, so input is blocked after it.
   a_reset_blocks: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("input accepted right after reset");

endmodule

bind present80_block_cipher p80_checker u_p80_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite)
);

`default_nettype wire

### dv/tb_present80_block_cipher.sv
// Self-checking testbench for the PRESENT-80 block cipher core.
`default_nettype none

module tb_present80_block_cipher;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] ZERO64 = 64'h0;
   localparam logic [63:0] ONES64 = 64'hffff_ffff_ffff_ffff;

   // The 4-bit S-box and its inverse, entry 0 in the lowest nibble.
   localparam logic [63:0] SBOX_NIBBLES     = 64'h2174_8fe3_da09_b65c;
   localparam logic [63:0] INV_SBOX_NIBBLES = 64'ha970_364b_d21c_8fe5;

   // Receiver stall modes.
   localparam int unsigned RX_ALWAYS  = 0;
   localparam int unsigned RX_HALF    = 1;
   localparam int unsigned RX_SPARSE  = 2;
   localparam int unsigned RX_PERIOD  = 3;

   localparam int unsigned RANDOM_PHASES   = 8;
   localparam int unsigned ITEMS_PER_PHASE = 190;
   localparam int unsigned LONG_HOLD       = 200;
   localparam int unsigned DRAIN_CYCLES    = 40;

   // One row of the directed table. Where known is set, result was read off
   // the published cipher vectors; otherwise the predictor supplies it.
   typedef struct packed {
      logic [63:0] key_hi;
      logic [15:0] key_lo;
      logic        dir;
      logic [63:0] text;
      logic        known;
      logic [63:0] result;
   } cipher_vector_type;

   localparam cipher_vector_type DIRECTED [0:17] = '{
      // All-zero key straight out of reset: no register write is done first.
      '{ZERO64, 16'h0000, p80_pkg::DIR_ENCRYPT, ZERO64, 1'b1, 64'h5579_c138_7b22_8445},
      '{ZERO64, 16'h0000, p80_pkg::DIR_ENCRYPT, ONES64, 1'b1, 64'ha112_ffc7_2f68_417b},
      '{ZERO64, 16'h0000, p80_pkg::DIR_DECRYPT, 64'h5579_c138_7b22_8445, 1'b1, ZERO64},
      '{ZERO64, 16'h0000, p80_pkg::DIR_DECRYPT, 64'ha112_ffc7_2f68_417b, 1'b1, ONES64},
      '{ZERO64, 16'h0000, p80_pkg::DIR_DECRYPT, ZERO64, 1'b0, ZERO64},
      // All-ones key.
      '{ONES64, 16'hffff, p80_pkg::DIR_ENCRYPT, ZERO64, 1'b1, 64'he72c_46c0_f594_5049},
      '{ONES64, 16'hffff, p80_pkg::DIR_ENCRYPT, ONES64, 1'b1, 64'h3333_dcd3_2132_10d2},
      '{ONES64, 16'hffff, p80_pkg::DIR_DECRYPT, 64'he72c_46c0_f594_5049, 1'b1, ZERO64},
      '{ONES64, 16'hffff, p80_pkg::DIR_DECRYPT, 64'h3333_dcd3_2132_10d2, 1'b1, ONES64},
      '{ONES64, 16'hffff, p80_pkg::DIR_DECRYPT, ONES64, 1'b0, ZERO64},
      '{ONES64, 16'hffff, p80_pkg::DIR_ENCRYPT, 64'h8000_0000_0000_0000, 1'b0, ZERO64},
      '{ONES64, 16'hffff, p80_pkg::DIR_ENCRYPT, 64'h0000_0000_0000_0001, 1'b0, ZERO64},
      // Only one of the two key registers nonzero.
      '{ZERO64, 16'hffff, p80_pkg::DIR_ENCRYPT, ZERO64, 1'b0, ZERO64},
      '{ZERO64, 16'hffff, p80_pkg::DIR_DECRYPT, 64'h0123_4567_89ab_cdef, 1'b0, ZERO64},
      '{ONES64, 16'h0000, p80_pkg::DIR_ENCRYPT, 64'h0123_4567_89ab_cdef, 1'b0, ZERO64},
      '{ONES64, 16'h0000, p80_pkg::DIR_DECRYPT, 64'hfedc_ba98_7654_3210, 1'b0, ZERO64},
      // Key with only the end bits of each key register set.
      '{64'h8000_0000_0000_0001, 16'h8001, p80_pkg::DIR_ENCRYPT, 64'h5555_5555_5555_5555,
        1'b0, ZERO64},
      '{64'h8000_0000_0000_0001, 16'h8001, p80_pkg::DIR_DECRYPT, 64'haaaa_aaaa_aaaa_aaaa,
        1'b0, ZERO64}
   };

   // Every input of the block starts at a known value.
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata   = '0;
   logic        req_tuser   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [63:0] rsp_tdata;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [63:0] csr_pwdata  = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   present80_block_cipher dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // The predictor's copy of the key and the round keys derived from it.
   logic [63:0] key_hi = '0;
   logic [15:0] key_lo = '0;
   logic [63:0] round_key [0:31];

   // Cipher blocks still owed by the block, oldest first.
   logic [63:0] expected_blocks [$];
   logic [63:0] owed_block;
   int unsigned mismatches = 0;

   // Sender pacing: items left in the current burst, and items that must go
   // out with no gap while the receiver is holding off.
   int unsigned burst_left  = 1;
   int unsigned no_gap_left = 0;

   // Long hold-offs asked for by the sender and served by the receiver.
   int unsigned holds_asked = 0;
   int unsigned holds_given = 0;
   int unsigned hold_left   = 0;
   int unsigned stall_mode  = RX_ALWAYS;
   int unsigned window_left = 0;
   logic [2:0]  stall_phase = '0;

   initial begin
      forever #5 clock = ~clock;
   end

   // A correct run needs well under a tenth of this time.
   initial begin
      #2_000_000;
      $display("FAIL present80_block_cipher");
      $finish;
   end

   function automatic logic [63:0] sbox_layer(input logic [63:0] s, input logic inverse);
      logic [63:0] o;
      for (int n = 0; n < 16; n++) begin
         o[4*n +: 4] = inverse ? INV_SBOX_NIBBLES[4*s[4*n +: 4] +: 4]
                               : SBOX_NIBBLES[4*s[4*n +: 4] +: 4];
      end
      return o;
   endfunction

   // Bit k lands on (mul*k) mod 63; the top bit never moves. A multiplier of
   // 16 gives the forward wiring and 4 its inverse.
   function automatic logic [63:0] bit_shuffle(input logic [63:0] s, input int unsigned mul);
      logic [63:0] o;
      o = '0;
      for (int k = 0; k < 63; k++) begin
         o[(mul*k) % 63] = s[k];
      end
      o[63] = s[63];
      return o;
   endfunction

   // Round key r is the top 64 bits of the 80-bit key register before its
   // r-th update: rotate left by 61, S-box the top nibble, fold in r+1.
   task automatic build_schedule();
      logic [79:0] k;
      k = {key_hi, key_lo};
      for (int r = 0; r < 32; r++) begin
         round_key[r] = k[79:16];
         k = {k[18:0], k[79:19]};
         k[79:76] = SBOX_NIBBLES[4*k[79:76] +: 4];
         k[19:15] = k[19:15] ^ 5'(r + 1);
      end
   endtask

   function automatic logic [63:0] present_crypt(input logic dir, input logic [63:0] text);
      logic [63:0] s;
      s = text;
      if (dir == p80_pkg::DIR_ENCRYPT) begin
         for (int i = 0; i < 31; i++) begin
            s = bit_shuffle(sbox_layer(s ^ round_key[i], 1'b0), 16);
         end
         s = s ^ round_key[31];
      end else begin
         for (int i = 0; i < 31; i++) begin
            s = sbox_layer(bit_shuffle(s ^ round_key[31-i], 4), 1'b1);
         end
         s = s ^ round_key[0];
      end
      return s;
   endfunction

   // Blocks for the random part: half uniform, half degenerate patterns that
   // stress single bits and whole nibbles.
   function automatic logic [63:0] pick_text();
      logic [63:0] one_hot;
      one_hot = 64'h1 << $urandom_range(0, 63);
      case ($urandom_range(0, 9))
         0: return ZERO64;
         1: return ONES64;
         2: return one_hot;
         3: return ~one_hot;
         4: return {16{4'($urandom)}};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Offers one item and waits for the block to take it. Valid stays high
   // into the next item unless the burst ends with a real gap.
   task automatic send_block(input logic dir, input logic [63:0] text,
                             input logic known, input logic [63:0] result);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= dir;
      req_tdata  <= text;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_blocks.push_back(known ? result : present_crypt(dir, text));
      if (no_gap_left > 0) no_gap_left--;
      burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0 || no_gap_left > 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // One write on the configuration port: setup cycle, then access cycle.
   task automatic csr_write(input logic index, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Keys change only with the block empty. The lower register is written
   // with junk above bit 15, which the block has to drop.
   task automatic load_key(input logic [63:0] hi, input logic [15:0] lo);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write(p80_pkg::REG_KEY_UPPER, hi);
      csr_write(p80_pkg::REG_KEY_LOWER, {$urandom, 16'($urandom), lo});
      key_hi = hi;
      key_lo = lo;
      build_schedule();
   endtask

   // Receiver: checks every accepted item against the oldest expected block,
   // then decides its ready for the next cycle. A long hold-off asked for by
   // the sender takes priority over the normal stall pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_blocks.size() == 0) begin
               $display("%0t: text_out %h arrived with nothing expected", $time, rsp_tdata);
               mismatches++;
            end else begin
               owed_block = expected_blocks.pop_front();
               if (rsp_tdata !== owed_block) begin
                  $display("%0t: text_out mismatch, expected %h, actual %h",
                           $time, owed_block, rsp_tdata);
                  mismatches++;
               end
            end
         end
         stall_phase <= stall_phase + 3'd1;
         if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (holds_given != holds_asked) begin
            holds_given <= holds_given + 1;
            hold_left   <= LONG_HOLD;
            rsp_tready  <= 1'b0;
         end else begin
            if (window_left == 0) begin
               stall_mode  <= $urandom_range(RX_ALWAYS, RX_PERIOD);
               window_left <= $urandom_range(20, 200);
            end else begin
               window_left <= window_left - 1;
            end
            case (stall_mode)
               RX_ALWAYS: rsp_tready <= 1'b1;
               RX_HALF:   rsp_tready <= 1'($urandom);
               RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:   rsp_tready <= (stall_phase[1:0] != 2'b00);
            endcase
         end
      end
   end

   // Sender: reset, the directed table, then random phases under changing keys.
   initial begin
      logic [63:0] hi;
      logic [15:0] lo;
      build_schedule();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // The block is not ready until its key row has refilled; the handshake
      // covers that wait. A row with a new key first drains and rewrites it.
      for (int i = 0; i < 18; i++) begin
         if (DIRECTED[i].key_hi != key_hi || DIRECTED[i].key_lo != key_lo) begin
            load_key(DIRECTED[i].key_hi, DIRECTED[i].key_lo);
         end
         send_block(DIRECTED[i].dir, DIRECTED[i].text, DIRECTED[i].known,
                    DIRECTED[i].result);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            1: begin
               hi = ZERO64;
               lo = 16'h0000;
            end
            4: begin
               hi = ONES64;
               lo = 16'hffff;
            end
            default: begin
               hi = {$urandom, $urandom};
               lo = 16'($urandom);
            end
         endcase
         load_key(hi, lo);
         // In two phases the receiver holds off for a long stretch while the
         // sender keeps offering, so the pipeline fills and backs up.
         if (phase == 2 || phase == 6) begin
            holds_asked <= holds_asked + 1;
            no_gap_left = 120;
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_block(1'($urandom), pick_text(), 1'b0, ZERO64);
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS present80_block_cipher");
      end else begin
         $display("FAIL present80_block_cipher");
      end
      $finish;
   end

endmodule

`default_nettype wire
